@@ src/subset_sum_reachability_macros.svh @@
// Assertion helpers for the module that checks its own logic.
`ifndef SUBSET_SUM_REACHABILITY_MACROS_SVH
`define SUBSET_SUM_REACHABILITY_MACROS_SVH

// Same-cycle implication, sampled on the block clock and quiet during reset.
`define SSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock and quiet during reset.
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ssr_pkg.sv @@
package ssr_pkg;

    localparam int WORD_W    = 64;
    localparam int WORD_LSB  = 6;
    localparam int VALUE_W   = 10;
    localparam int Q_W       = VALUE_W - WORD_LSB;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef logic [WORD_W-1:0] t_word;

    // Where the word being shifted in comes from during a sweep.
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_HEAD,
        SRC_DELAY,
        SRC_RAM
    } t_src_sel;

    typedef struct packed {
        logic step;
        logic clear;
    } t_ring_ctl;

    typedef struct packed {
        logic                step;
        logic                first;
        logic                top;
        t_src_sel            sel;
        logic [WORD_LSB-1:0] bit_shift;
    } t_merge_ctl;

endpackage

@@ src/ssr_bitmap_ring.sv @@
module ssr_bitmap_ring #(
    parameter int WORD_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssr_pkg::t_ring_ctl i_ctl,
    input  ssr_pkg::t_word    i_tail,
    output ssr_pkg::t_word    o_head
);

    ssr_pkg::t_word r_ring [WORD_COUNT];

    // The bitmap rotates one word per step; word 0 sits at the head between sweeps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int k = 0; k < WORD_COUNT; k++) begin
                r_ring[k] <= (k == 0) ? ssr_pkg::t_word'(1) : '0;
            end
        end else if (i_ctl.step) begin
            for (int k = 0; k < WORD_COUNT - 1; k++) begin
                r_ring[k] <= r_ring[k+1];
            end
            r_ring[WORD_COUNT-1] <= i_tail;
        end
    end

    assign o_head = r_ring[0];

endmodule

@@ src/ssr_hist_ram.sv @@
module ssr_hist_ram #(
    parameter int WORD_COUNT = 16,
    parameter int ADDR_W     = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  ssr_pkg::t_word    i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output ssr_pkg::t_word    o_rd_data
);

    ssr_pkg::t_word r_mem [WORD_COUNT];
    ssr_pkg::t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/ssr_word_merge.sv @@
module ssr_word_merge #(
    parameter int TOP_BITS = 64
) (
    input  logic               i_clk,
    input  ssr_pkg::t_merge_ctl i_ctl,
    input  ssr_pkg::t_word     i_head,
    input  ssr_pkg::t_word     i_ram_data,
    output ssr_pkg::t_word     o_word
);

    localparam ssr_pkg::t_word TOP_MASK =
        ssr_pkg::t_word'({ssr_pkg::WORD_W{1'b1}} >> (ssr_pkg::WORD_W - TOP_BITS));

    ssr_pkg::t_word                   r_delay;
    ssr_pkg::t_word                   r_prev;
    ssr_pkg::t_word                   w_src;
    ssr_pkg::t_word                   w_prev;
    logic [2*ssr_pkg::WORD_W-1:0]     w_pair;
    ssr_pkg::t_word                   w_merged;

    always_comb begin
        case (i_ctl.sel)
            ssr_pkg::SRC_ZERO:  w_src = '0;
            ssr_pkg::SRC_HEAD:  w_src = i_head;
            ssr_pkg::SRC_DELAY: w_src = r_delay;
            ssr_pkg::SRC_RAM:   w_src = i_ram_data;
            default:            w_src = '0;
        endcase
    end

    // The shifted word takes its low bits from the top of the word before it.
    assign w_prev   = i_ctl.first ? '0 : r_prev;
    assign w_pair   = {w_src, w_prev} << i_ctl.bit_shift;
    assign w_merged = i_head | w_pair[2*ssr_pkg::WORD_W-1:ssr_pkg::WORD_W];
    assign o_word   = i_ctl.top ? (w_merged & TOP_MASK) : w_merged;

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_delay <= i_head;
            r_prev  <= w_src;
        end
    end

endmodule

@@ src/subset_sum_reachability.sv @@
// Subset-sum reachability. Each input word carries one set element; the block keeps a
// bitmap of the sums from 0 to MAX_SUM that some subset reaches, and on the word marked
// tlast it returns one bit that tells whether the target sum is reachable, then starts a
// new set with only sum zero. The bitmap lives in a ring of 64-bit words that rotates one
// word per cycle while an element is swept; no new element is taken until the sweep of
// the last one is through, and the final element of a set also passes a done state that
// moves the answer into the output register. Earlier bitmap words for the
// word-aligned part of the shift come from a small history RAM of the same depth as the
// ring. A waiting answer does not hold up the next set; only a second answer does.
`include "subset_sum_reachability_macros.svh"

module subset_sum_reachability #(
    parameter int MAX_SUM = 1023
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // element_value [9:0], target_sum [19:10], zero fill [23:20]
    input  logic [ssr_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // reachable [0], zero fill [7:1]
    output logic [ssr_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    localparam int WORD_COUNT = MAX_SUM / ssr_pkg::WORD_W + 1;
    localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int TOP_BITS   = MAX_SUM % ssr_pkg::WORD_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state                         r_state, n_state;
    logic [IDX_W-1:0]               r_cnt;
    logic [ssr_pkg::Q_W-1:0]        r_q;
    logic [ssr_pkg::WORD_LSB-1:0]   r_r;
    logic [ssr_pkg::Q_W-1:0]        r_tw;
    logic [ssr_pkg::WORD_LSB-1:0]   r_tb;
    logic                           r_last;
    logic                           r_hit, n_hit;
    logic                           r_out_valid;
    logic                           r_out_data;

    logic                 w_accept;
    logic                 w_step;
    logic                 w_final;
    logic                 w_load;
    ssr_pkg::t_word       w_head;
    ssr_pkg::t_word       w_new;
    ssr_pkg::t_word       w_ram_data;
    logic [IDX_W-1:0]     w_rd_addr;
    ssr_pkg::t_ring_ctl   w_ring_ctl;
    ssr_pkg::t_merge_ctl  w_merge_ctl;
    ssr_pkg::t_src_sel    w_sel;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_step     = (r_state == S_SWEEP);
    assign w_final    = w_step && (int'(r_cnt) == WORD_COUNT - 1);
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    // Word w of the shifted copy needs old word w - q; below q it is all zero.
    always_comb begin
        if (int'(r_cnt) < int'(r_q)) begin
            w_sel = ssr_pkg::SRC_ZERO;
        end else if (r_q == '0) begin
            w_sel = ssr_pkg::SRC_HEAD;
        end else if (int'(r_q) == 1) begin
            w_sel = ssr_pkg::SRC_DELAY;
        end else begin
            w_sel = ssr_pkg::SRC_RAM;
        end
    end

    // The RAM is read one step ahead, so its registered data meets the right step.
    assign w_rd_addr = IDX_W'(int'(r_cnt) + 1 - int'(r_q));

    assign w_ring_ctl.step  = w_step;
    assign w_ring_ctl.clear = w_load;

    assign w_merge_ctl.step      = w_step;
    assign w_merge_ctl.first     = w_step && (r_cnt == '0);
    assign w_merge_ctl.top       = (int'(r_cnt) == WORD_COUNT - 1);
    assign w_merge_ctl.sel       = w_sel;
    assign w_merge_ctl.bit_shift = r_r;

    ssr_bitmap_ring #(
        .WORD_COUNT (WORD_COUNT)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ring_ctl),
        .i_tail  (w_new),
        .o_head  (w_head)
    );

    ssr_hist_ram #(
        .WORD_COUNT (WORD_COUNT),
        .ADDR_W     (IDX_W)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (w_step),
        .i_wr_addr (r_cnt),
        .i_wr_data (w_head),
        .i_rd_en   (w_step),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_data)
    );

    ssr_word_merge #(
        .TOP_BITS (TOP_BITS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_ctl      (w_merge_ctl),
        .i_head     (w_head),
        .i_ram_data (w_ram_data),
        .o_word     (w_new)
    );

    // A target beyond the bitmap never matches a word, so the answer stays zero.
    always_comb begin
        n_hit = r_hit;
        if (w_accept) begin
            n_hit = 1'b0;
        end else if (w_step && (int'(r_cnt) == int'(r_tw))) begin
            n_hit = w_new[r_tb];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (w_final) begin
                    n_state = r_last ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
            if (w_accept) begin
                r_cnt  <= '0;
                r_last <= i_s_tlast;
            end else if (w_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_q  <= i_s_tdata[ssr_pkg::VALUE_W-1:ssr_pkg::WORD_LSB];
            r_r  <= i_s_tdata[ssr_pkg::WORD_LSB-1:0];
            r_tw <= i_s_tdata[2*ssr_pkg::VALUE_W-1:ssr_pkg::VALUE_W+ssr_pkg::WORD_LSB];
            r_tb <= i_s_tdata[ssr_pkg::VALUE_W+ssr_pkg::WORD_LSB-1:ssr_pkg::VALUE_W];
        end
        if (w_load) begin
            r_out_data <= r_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(ssr_pkg::M_TDATA_W-1){1'b0}}, r_out_data};

    `SSR_ASSERT_NOW(a_zero_sum_kept, r_state == S_IDLE, w_head[0], "sum zero missing from head word")
    `SSR_ASSERT_NOW(a_cnt_range, r_state == S_SWEEP, int'(r_cnt) < WORD_COUNT, "sweep count out of range")
    `SSR_ASSERT_NOW(a_result_source, $rose(o_m_tvalid), $past(r_state == S_DONE), "word without a set end")

endmodule
